@@ sv/tkr_pkg.sv @@
package tkr_pkg;

    localparam int KEY_W    = 64;
    localparam int COUNT_W  = 31;
    localparam int RANK_W   = 3;
    localparam int SEC_W    = 8;
    localparam int PERIOD_W = 8;

    localparam logic [SEC_W-1:0]    SEC_MAX      = 8'hFF;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd1;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [KEY_W-1:0]   item_key;
        logic [COUNT_W-1:0] item_count;
        logic               tuple_end;
    } item_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank_position;
        logic [KEY_W-1:0]   ranked_key;
        logic [COUNT_W-1:0] ranked_count;
        logic               last_rank;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } slot_t;

endpackage

@@ sv/tkr_table.sv @@
module tkr_table
    import tkr_pkg::*;
#(
    parameter int TOP_COUNT = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  item_t                         item,
    input  logic                          fire,
    input  logic [PERIOD_W-1:0]           period,
    output logic                          emit_now,
    output slot_t [TOP_COUNT-1:0]         snap
);

    localparam int SLOTS = TOP_COUNT + 1;
    localparam int IDX_W = $clog2(SLOTS);

    slot_t [SLOTS-1:0] slot_reg;
    slot_t [SLOTS-1:0] slot_next;
    slot_t [SLOTS-1:0] shift_tab;
    slot_t [SLOTS-1:0] eff_tab;
    logic  [SLOTS-1:0] valid_reg;
    logic  [SLOTS-1:0] valid_next;
    logic  [SLOTS-1:0] shift_vld;
    logic  [SLOTS-1:0] eff_vld;
    logic  [SEC_W-1:0] sec_reg;
    logic  [SEC_W-1:0] sec_next;
    logic  [IDX_W-1:0] hit;
    logic  [IDX_W-1:0] pos;
    logic  [IDX_W-1:0] pp;
    logic              take;
    slot_t             new_slot;

    always_comb begin
        new_slot.key   = item.item_key;
        new_slot.count = item.item_count;
        take = (item.kind == KIND_ENTRY) && (item.item_count != '0);

        hit = IDX_W'(SLOTS - 1);
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (valid_reg[i] && (slot_reg[i].key == item.item_key)) begin
                hit = IDX_W'(i);
            end
        end

        pos = '0;
        for (int j = 0; j < SLOTS; j++) begin
            if (IDX_W'(j) < hit) begin
                if (slot_reg[j].count >= item.item_count) begin
                    pos = pos + IDX_W'(1);
                end
            end else if (IDX_W'(j) > hit) begin
                if (slot_reg[j].count > item.item_count) begin
                    pos = pos + IDX_W'(1);
                end
            end
        end

        for (int p = 0; p < SLOTS; p++) begin
            pp = IDX_W'(p);
            if (pp == pos) begin
                shift_tab[p] = new_slot;
                shift_vld[p] = 1'b1;
            end else if ((p < SLOTS - 1) && (pp >= hit) && (pp < pos)) begin
                shift_tab[p] = slot_reg[p+1];
                shift_vld[p] = valid_reg[p+1];
            end else if ((p > 0) && (pp > pos) && (pp <= hit)) begin
                shift_tab[p] = slot_reg[p-1];
                shift_vld[p] = valid_reg[p-1];
            end else begin
                shift_tab[p] = slot_reg[p];
                shift_vld[p] = valid_reg[p];
            end
        end

        eff_tab = take ? shift_tab : slot_reg;
        eff_vld = take ? shift_vld : valid_reg;

        for (int k = 0; k < TOP_COUNT; k++) begin
            snap[k] = eff_vld[k] ? eff_tab[k] : '0;
        end

        emit_now = (item.kind == KIND_ENTRY) && item.tuple_end && (sec_reg >= period);

        sec_next = sec_reg;
        if (item.kind == KIND_TICK) begin
            if (sec_reg != SEC_MAX) begin
                sec_next = sec_reg + SEC_W'(1);
            end
        end else if (emit_now) begin
            sec_next = '0;
        end

        slot_next  = fire ? eff_tab : slot_reg;
        valid_next = fire ? eff_vld : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            valid_reg <= '0;
            sec_reg   <= SEC_MAX;
        end else begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
            if (fire) begin
                sec_reg <= sec_next;
            end
        end
    end

endmodule

@@ sv/tkr_emit.sv @@
module tkr_emit
    import tkr_pkg::*;
#(
    parameter int TOP_COUNT = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  slot_t [TOP_COUNT-1:0] snap,
    output logic                  busy,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data
);

    localparam int RK_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    slot_t [TOP_COUNT-1:0] snap_reg;
    logic  [RK_W-1:0]      rank_reg;
    logic                  busy_reg;
    logic                  last;
    logic  [31:0]          rank_ext;

    assign last     = (rank_reg == RK_W'(TOP_COUNT - 1));
    assign rank_ext = 32'(rank_reg);
    assign busy     = busy_reg;
    assign m_valid  = busy_reg;

    always_comb begin
        m_data.rank_position = rank_ext[RANK_W-1:0];
        m_data.ranked_key    = snap_reg[0].key;
        m_data.ranked_count  = snap_reg[0].count;
        m_data.last_rank     = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rank_reg <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            rank_reg <= '0;
        end else if (busy_reg && m_ready) begin
            rank_reg <= rank_reg + RK_W'(1);
            if (last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            snap_reg <= snap;
        end else if (busy_reg && m_ready) begin
            for (int i = 0; i < TOP_COUNT - 1; i++) begin
                snap_reg[i] <= snap_reg[i+1];
            end
        end
    end

endmodule

@@ sv/top_k_ranker_top.sv @@
// An entry request is registered on accept; when it fires, it is applied to the table
// and the ranked snapshot is loaded into the emitter at the same edge, which then offers it.
// One request per cycle, except that an emitting request waits while a previous emission
// drains: TOP_COUNT ranked results at one ranked result per cycle while m_ready is held high.
// Reset: synchronous, active low; empties the table, sets seconds to 255, period to 1.
module top_k_ranker_top
    import tkr_pkg::*;
#(
    parameter int TOP_COUNT = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  item_t               s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output result_t             m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] cfg_data
);

    item_t                 in_reg;
    logic                  in_vld_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic                  emit_now;
    logic                  busy;
    logic                  fire;
    slot_t [TOP_COUNT-1:0] snap;

    assign fire      = in_vld_reg && (!busy || !emit_now);
    assign s_ready   = !in_vld_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            period_reg <= PERIOD_RESET;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (cfg_valid) begin
                period_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    tkr_table #(
        .TOP_COUNT (TOP_COUNT)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (in_reg),
        .fire     (fire),
        .period   (period_reg),
        .emit_now (emit_now),
        .snap     (snap)
    );

    tkr_emit #(
        .TOP_COUNT (TOP_COUNT)
    ) u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire && emit_now),
        .snap    (snap),
        .busy    (busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
